/* src/spas_pkg.sv */
// shared types and constants for the sparse polynomial add/sub block
package spas_pkg;

    localparam int COEF_W = 24;
    localparam int EXP_W  = 16;
    localparam int RES_W  = 25;
    localparam int OP_W   = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_ADD    = 2'd2,
        OP_SUB    = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_MERGE = 1'b1
    } state_t;

    typedef struct packed {
        logic                     take_a;
        logic                     take_b;
        logic signed [RES_W-1:0]  coef;
        logic signed [EXP_W-1:0]  exp;
    } step_t;

endpackage

/* src/sparse_polynomial_add_sub.sv */
// top level: term loading, merge sequencer and output register
//
// channel  dir  beat contents
// s_*      in   tdata: opcode[1:0], coefficient[25:2], exponent[41:26]
// m_*      out  tdata: result_coefficient[24:0], result_exponent[40:25];
//               tlast: last_term; tuser: zero_polynomial
//
// loads may come back to back; the stores insert in sorted order
// a compute runs one merge step per cycle while the output register is free, through
// the shared add/compare unit, where steps = na + nb - matched exponent pairs
// m_tready low stalls the merge; s_tready stays low until the last beat is registered
// reset empties both stores and the output register
module sparse_polynomial_add_sub #(
    parameter int MAX_TERMS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // opcode, coefficient, exponent, zero pad
    input  logic [spas_pkg::IN_TDATA_W-1:0]       s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // result_coefficient, result_exponent, zero pad
    output logic [spas_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                  m_tlast,
    // zero_polynomial
    output logic                                  m_tuser
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int PAD_W = spas_pkg::OUT_TDATA_W - spas_pkg::RES_W - spas_pkg::EXP_W;

    spas_pkg::op_t                       in_op;
    logic signed [spas_pkg::COEF_W-1:0]  in_coef;
    logic signed [spas_pkg::EXP_W-1:0]   in_exp;
    logic                                in_fire;

    spas_pkg::state_t state_reg;
    spas_pkg::state_t state_next;

    logic [CNT_W-1:0] ia_reg;
    logic [CNT_W-1:0] ia_next;
    logic [CNT_W-1:0] jb_reg;
    logic [CNT_W-1:0] jb_next;
    logic             sub_reg;
    logic             sub_next;

    logic                               pend_valid_reg;
    logic                               pend_valid_next;
    logic signed [spas_pkg::RES_W-1:0]  pend_coef_reg;
    logic signed [spas_pkg::RES_W-1:0]  pend_coef_next;
    logic signed [spas_pkg::EXP_W-1:0]  pend_exp_reg;
    logic signed [spas_pkg::EXP_W-1:0]  pend_exp_next;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [spas_pkg::RES_W-1:0]  out_coef_reg;
    logic signed [spas_pkg::RES_W-1:0]  out_coef_next;
    logic signed [spas_pkg::EXP_W-1:0]  out_exp_reg;
    logic signed [spas_pkg::EXP_W-1:0]  out_exp_next;
    logic                               out_last_reg;
    logic                               out_last_next;
    logic                               out_zero_reg;
    logic                               out_zero_next;

    logic                               load_a;
    logic                               load_b;
    logic                               start;
    logic                               step_go;
    logic                               finish;
    logic                               out_free;
    logic                               a_avail;
    logic                               b_avail;
    logic                               merge_done;

    logic signed [spas_pkg::COEF_W-1:0] a_coef;
    logic signed [spas_pkg::EXP_W-1:0]  a_exp;
    logic signed [spas_pkg::COEF_W-1:0] b_coef;
    logic signed [spas_pkg::EXP_W-1:0]  b_exp;
    logic [CNT_W-1:0]                   count_a;
    logic [CNT_W-1:0]                   count_b;
    spas_pkg::step_t                    step;

    assign in_op   = spas_pkg::op_t'(s_tdata[spas_pkg::OP_W-1:0]);
    assign in_coef = s_tdata[spas_pkg::OP_W +: spas_pkg::COEF_W];
    assign in_exp  = s_tdata[spas_pkg::OP_W + spas_pkg::COEF_W +: spas_pkg::EXP_W];
    assign in_fire = s_tvalid && s_tready;

    assign out_free   = !out_valid_reg || m_tready;
    assign a_avail    = ia_reg < count_a;
    assign b_avail    = jb_reg < count_b;
    assign merge_done = !a_avail && !b_avail;

    spas_store #(
        .DEPTH (MAX_TERMS)
    ) u_store_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load_a),
        .clear   (finish),
        .in_coef (in_coef),
        .in_exp  (in_exp),
        .rd_idx  (ia_reg[IDX_W-1:0]),
        .rd_coef (a_coef),
        .rd_exp  (a_exp),
        .count   (count_a)
    );

    spas_store #(
        .DEPTH (MAX_TERMS)
    ) u_store_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load_b),
        .clear   (finish),
        .in_coef (in_coef),
        .in_exp  (in_exp),
        .rd_idx  (jb_reg[IDX_W-1:0]),
        .rd_coef (b_coef),
        .rd_exp  (b_exp),
        .count   (count_b)
    );

    spas_alu u_alu (
        .a_avail (a_avail),
        .b_avail (b_avail),
        .sub     (sub_reg),
        .a_coef  (a_coef),
        .a_exp   (a_exp),
        .b_coef  (b_coef),
        .b_exp   (b_exp),
        .step    (step)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spas_pkg::ST_IDLE:
            begin
                if (in_fire && (in_op == spas_pkg::OP_ADD || in_op == spas_pkg::OP_SUB))
                    state_next = spas_pkg::ST_MERGE;
            end
            spas_pkg::ST_MERGE:
            begin
                if (merge_done && out_free)
                    state_next = spas_pkg::ST_IDLE;
            end
            default:
                state_next = spas_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready = 1'b0;
        load_a   = 1'b0;
        load_b   = 1'b0;
        start    = 1'b0;
        step_go  = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            spas_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                load_a   = in_fire && (in_op == spas_pkg::OP_LOAD_A);
                load_b   = in_fire && (in_op == spas_pkg::OP_LOAD_B);
                start    = in_fire && (in_op == spas_pkg::OP_ADD || in_op == spas_pkg::OP_SUB);
            end
            spas_pkg::ST_MERGE:
            begin
                step_go = out_free && !merge_done;
                finish  = out_free && merge_done;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        ia_next         = ia_reg;
        jb_next         = jb_reg;
        sub_next        = sub_reg;
        pend_valid_next = pend_valid_reg;
        pend_coef_next  = pend_coef_reg;
        pend_exp_next   = pend_exp_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_coef_next   = out_coef_reg;
        out_exp_next    = out_exp_reg;
        out_last_next   = out_last_reg;
        out_zero_next   = out_zero_reg;

        if (start)
        begin
            ia_next         = '0;
            jb_next         = '0;
            sub_next        = (in_op == spas_pkg::OP_SUB);
            pend_valid_next = 1'b0;
        end

        if (step_go)
        begin
            ia_next = ia_reg + CNT_W'(step.take_a);
            jb_next = jb_reg + CNT_W'(step.take_b);
            if (step.coef != '0)
            begin
                pend_valid_next = 1'b1;
                pend_coef_next  = step.coef;
                pend_exp_next   = step.exp;
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_coef_next  = pend_coef_reg;
                    out_exp_next   = pend_exp_reg;
                    out_last_next  = 1'b0;
                    out_zero_next  = 1'b0;
                end
            end
        end

        if (finish)
        begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            out_last_next   = 1'b1;
            out_zero_next   = !pend_valid_reg;
            out_coef_next   = pend_valid_reg ? pend_coef_reg : '0;
            out_exp_next    = pend_valid_reg ? pend_exp_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spas_pkg::ST_IDLE;
            ia_reg         <= '0;
            jb_reg         <= '0;
            sub_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ia_reg         <= ia_next;
            jb_reg         <= jb_next;
            sub_reg        <= sub_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_coef_reg <= pend_coef_next;
        pend_exp_reg  <= pend_exp_next;
        out_coef_reg  <= out_coef_next;
        out_exp_reg   <= out_exp_next;
        out_last_reg  <= out_last_next;
        out_zero_reg  <= out_zero_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_exp_reg, out_coef_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_zero_reg;

endmodule

/* src/spas_store.sv */
// term store kept sorted by descending exponent, insertion after equal exponents
module spas_store #(
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load,
    input  logic                                  clear,
    input  logic signed [spas_pkg::COEF_W-1:0]    in_coef,
    input  logic signed [spas_pkg::EXP_W-1:0]     in_exp,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_idx,
    output logic signed [spas_pkg::COEF_W-1:0]    rd_coef,
    output logic signed [spas_pkg::EXP_W-1:0]     rd_exp,
    output logic [$clog2(DEPTH+1)-1:0]            count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [spas_pkg::COEF_W-1:0] coef_reg [DEPTH];
    logic signed [spas_pkg::EXP_W-1:0]  exp_reg  [DEPTH];
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic [DEPTH-1:0]                   ge;
    logic                               wr_en;

    assign wr_en = load && (count_reg < CNT_W'(DEPTH));

    for (genvar k = 0; k < DEPTH; k++) begin : g_entry
        assign ge[k] = (CNT_W'(k) < count_reg) && (exp_reg[k] >= in_exp);

        if (k == 0) begin : g_head
            always_ff @(posedge clk)
            begin
                if (wr_en && !ge[k])
                begin
                    coef_reg[k] <= in_coef;
                    exp_reg[k]  <= in_exp;
                end
            end
        end else begin : g_body
            always_ff @(posedge clk)
            begin
                if (wr_en && !ge[k])
                begin
                    if (ge[k-1])
                    begin
                        coef_reg[k] <= in_coef;
                        exp_reg[k]  <= in_exp;
                    end else begin
                        coef_reg[k] <= coef_reg[k-1];
                        exp_reg[k]  <= exp_reg[k-1];
                    end
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (clear)
            count_next = '0;
        else if (wr_en)
            count_next = count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign rd_coef = coef_reg[rd_idx];
    assign rd_exp  = exp_reg[rd_idx];
    assign count   = count_reg;

endmodule

/* src/spas_alu.sv */
// shared compare and add/subtract unit for one merge step
module spas_alu (
    input  logic                               a_avail,
    input  logic                               b_avail,
    input  logic                               sub,
    input  logic signed [spas_pkg::COEF_W-1:0] a_coef,
    input  logic signed [spas_pkg::EXP_W-1:0]  a_exp,
    input  logic signed [spas_pkg::COEF_W-1:0] b_coef,
    input  logic signed [spas_pkg::EXP_W-1:0]  b_exp,
    output spas_pkg::step_t                    step
);

    logic                              eq;
    logic                              b_only;
    logic                              use_a;
    logic                              use_b;
    logic signed [spas_pkg::RES_W-1:0] op_a;
    logic signed [spas_pkg::RES_W-1:0] op_b;

    always_comb
    begin
        eq     = a_avail && b_avail && (a_exp == b_exp);
        b_only = !eq && b_avail && (!a_avail || (a_exp < b_exp));
        use_a  = a_avail && !b_only;
        use_b  = eq || b_only;
        op_a   = use_a ? {a_coef[spas_pkg::COEF_W-1], a_coef} : '0;
        op_b   = use_b ? {b_coef[spas_pkg::COEF_W-1], b_coef} : '0;

        step.take_a = use_a;
        step.take_b = use_b;
        step.coef   = sub ? (op_a - op_b) : (op_a + op_b);
        step.exp    = use_a ? a_exp : b_exp;
    end

endmodule
